>>> sv/mcdc_pkg.sv
package mcdc_pkg;

    // Stream payload widths, whole bytes
    localparam int unsigned IN_W  = 80;
    localparam int unsigned OUT_W = 80;
    localparam int unsigned NUM_BTN = 3;

    // Configuration register codes
    typedef enum logic [0:0] {
        CFG_DBL_WINDOW  = 1'b0,
        CFG_DRAG_THRESH = 1'b1
    } t_cfg_reg;

    localparam logic [15:0] DBL_WINDOW_RST  = 16'd500;
    localparam logic [7:0]  DRAG_THRESH_RST = 8'd3;

    // Input frame, last field in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic signed [7:0]  wheel_step;
        logic [31:0]        time_ms;
        logic               middle_level;
        logic               right_level;
        logic               left_level;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } t_in_item;

    // Result frame, last field in the lowest bits
    typedef struct packed {
        logic [6:0]         pad;
        logic signed [31:0] wheel_before;
        logic signed [31:0] wheel_total;
        logic               middle_drag;
        logic               right_drag;
        logic               left_drag;
        logic               middle_double;
        logic               middle_single;
        logic               right_double;
        logic               right_single;
        logic               left_double;
        logic               left_single;
    } t_out_item;

endpackage

>>> sv/mouse_click_drag_classifier.sv
// Mouse click / double-click / drag classifier.
// Input stream (s_axis_*): one sampled pointer frame per transaction with
// position, the three button levels, a millisecond timestamp and a wheel step.
// Output stream (m_axis_*): exactly one result per input transaction with the
// single/double click events, the drag flags after the frame and the wheel
// sum before and after the frame.
// The frame is classified by combinational logic at acceptance and the result
// lands in the output register on the accepting edge.
// Throughput is one transaction per cycle while the receiver does not stall;
// the only state loop, the per-button, anchor and wheel state, updates at acceptance.
// A stalled receiver holds the result in the output register; a new frame is
// still taken in the cycle the held result is taken (tready follows the
// downstream tready when the output register is full).
// Configuration (i_cfg_*) writes the double-click window (index 0) and the
// drag threshold (index 1); write it only while no transaction is in flight.
// Reset (synchronous, active low) empties the output register, clears all
// button, anchor and wheel state and restores window 500 ms, threshold 3.
module mouse_click_drag_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_addr,
    input  logic [15:0]               i_cfg_wdata,
    // Input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata, low bit up: pos_x[16], pos_y[16], left_level, right_level,
    // middle_level, time_ms[32], wheel_step[8], zero fill[5]
    input  logic [mcdc_pkg::IN_W-1:0] s_axis_tdata,
    // Output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata, low bit up: left_single, left_double, right_single, right_double,
    // middle_single, middle_double, left_drag, right_drag, middle_drag,
    // wheel_total[32], wheel_before[32], zero fill[7]
    output logic [mcdc_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int unsigned NB = mcdc_pkg::NUM_BTN;

    // Configuration registers
    logic [15:0] r_dbl_window;
    logic [7:0]  r_drag_thresh;

    // Classifier state
    logic [NB-1:0]     r_prev;
    logic [31:0]       r_stamp [NB];
    logic [NB-1:0]     r_drag;
    logic signed [15:0] r_anchor_x;
    logic signed [15:0] r_anchor_y;
    logic signed [31:0] r_wheel;

    logic [NB-1:0]      n_prev;
    logic [31:0]        n_stamp [NB];
    logic [NB-1:0]      n_drag;
    logic signed [15:0] n_anchor_x;
    logic signed [15:0] n_anchor_y;
    logic signed [31:0] n_wheel;

    // Output register
    logic                r_out_valid;
    mcdc_pkg::t_out_item r_out;
    mcdc_pkg::t_out_item n_out;

    mcdc_pkg::t_in_item w_in;
    logic               w_accept;
    logic [NB-1:0]      w_single;
    logic [NB-1:0]      w_double;
    logic               w_pressed;
    logic               w_moved;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [16:0]        w_adx;
    logic [16:0]        w_ady;
    logic signed [32:0] w_sum;

    assign w_in          = mcdc_pkg::t_in_item'(s_axis_tdata);
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Frame classification
    always_comb begin
        logic [NB-1:0] lvl;
        logic [31:0]   elapsed;
        lvl       = {w_in.middle_level, w_in.right_level, w_in.left_level};
        n_prev    = lvl;
        n_drag    = r_drag;
        w_single  = '0;
        w_double  = '0;
        w_pressed = 1'b0;
        elapsed   = '0;
        for (int b = 0; b < NB; b++) begin
            n_stamp[b] = r_stamp[b];
            if (r_prev[b] && !lvl[b]) begin
                elapsed = w_in.time_ms - r_stamp[b];
                if (elapsed < {16'd0, r_dbl_window}) begin
                    w_double[b] = 1'b1;
                    n_stamp[b]  = '0;
                end else begin
                    w_single[b] = 1'b1;
                    n_stamp[b]  = w_in.time_ms;
                end
                n_drag[b] = 1'b0;
            end
            if (!r_prev[b] && lvl[b]) begin
                w_pressed = 1'b1;
            end
        end

        // Distance from the anchor, exact over the full 16-bit range
        w_dx  = {w_in.pos_x[15], w_in.pos_x} - {r_anchor_x[15], r_anchor_x};
        w_dy  = {w_in.pos_y[15], w_in.pos_y} - {r_anchor_y[15], r_anchor_y};
        w_adx = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
        w_ady = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
        w_moved = (w_adx > {9'd0, r_drag_thresh}) || (w_ady > {9'd0, r_drag_thresh});

        n_anchor_x = r_anchor_x;
        n_anchor_y = r_anchor_y;
        if (w_pressed) begin
            n_anchor_x = w_in.pos_x;
            n_anchor_y = w_in.pos_y;
        end else if (w_moved) begin
            n_drag = n_drag | lvl;
        end

        // Saturating wheel sum
        w_sum = {r_wheel[31], r_wheel} + 33'(w_in.wheel_step);
        if (w_sum[32] != w_sum[31]) begin
            n_wheel = w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_wheel = w_sum[31:0];
        end

        n_out               = '0;
        n_out.left_single   = w_single[0];
        n_out.left_double   = w_double[0];
        n_out.right_single  = w_single[1];
        n_out.right_double  = w_double[1];
        n_out.middle_single = w_single[2];
        n_out.middle_double = w_double[2];
        n_out.left_drag     = n_drag[0];
        n_out.right_drag    = n_drag[1];
        n_out.middle_drag   = n_drag[2];
        n_out.wheel_total   = n_wheel;
        n_out.wheel_before  = r_wheel;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbl_window  <= mcdc_pkg::DBL_WINDOW_RST;
            r_drag_thresh <= mcdc_pkg::DRAG_THRESH_RST;
        end else if (i_cfg_we) begin
            case (mcdc_pkg::t_cfg_reg'(i_cfg_addr))
                mcdc_pkg::CFG_DBL_WINDOW:  r_dbl_window  <= i_cfg_wdata;
                mcdc_pkg::CFG_DRAG_THRESH: r_drag_thresh <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // State update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_drag     <= '0;
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_wheel    <= '0;
            for (int b = 0; b < NB; b++) begin
                r_stamp[b] <= '0;
            end
        end else if (w_accept) begin
            r_prev     <= n_prev;
            r_drag     <= n_drag;
            r_anchor_x <= n_anchor_x;
            r_anchor_y <= n_anchor_y;
            r_wheel    <= n_wheel;
            for (int b = 0; b < NB; b++) begin
                r_stamp[b] <= n_stamp[b];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    // A release is either single or double, never both
    a_click_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.left_single && r_out.left_double) &&
                        !(r_out.right_single && r_out.right_double) &&
                        !(r_out.middle_single && r_out.middle_double))
        else $error("single and double click reported together");

    // A released left button cannot be dragging after the frame
    a_release_drag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.left_single || r_out.left_double) |-> !r_out.left_drag)
        else $error("left drag set on release");

    // Result wheel total matches the stored wheel state
    a_wheel_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out.wheel_total == r_wheel)
        else $error("wheel total out of step with state");

    // A left double click clears the stored left stamp
    a_dbl_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_double[0] |=> r_stamp[0] == 32'd0)
        else $error("left stamp not cleared after double click");

    // Empty output register never stalls the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty output register");
`endif

endmodule

>>> sim/click_drag_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both streams, predicts each result frame
// from the accepted pointer frame and compares it field by field.
module click_drag_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_addr,
    input  logic [15:0]                i_cfg_wdata,
    input  logic                       i_in_tvalid,
    input  logic                       i_in_tready,
    // low bit up: pos_x, pos_y, left/right/middle level, time_ms, wheel_step
    input  logic [mcdc_pkg::IN_W-1:0]  i_in_tdata,
    input  logic                       i_out_tvalid,
    input  logic                       i_out_tready,
    // low bit up: click events, drag flags, wheel_total, wheel_before
    input  logic [mcdc_pkg::OUT_W-1:0] i_out_tdata,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam longint WHEEL_MAX = 2147483647;
    localparam longint WHEEL_MIN = -WHEEL_MAX - 1;

    // Shadow copy of the classifier state and settings
    logic [15:0]        dbl_window;
    logic [7:0]         drag_thresh;
    logic [2:0]         btn_prev;
    logic [2:0]         drag_flag;
    logic [31:0]        click_stamp [mcdc_pkg::NUM_BTN];
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic signed [31:0] wheel_sum;

    mcdc_pkg::t_out_item predicted_frames [$];
    mcdc_pkg::t_out_item want_frame;
    mcdc_pkg::t_out_item got_frame;
    int                  mismatch_count = 0;

    // Classify one pointer frame and advance the shadow state
    function automatic mcdc_pkg::t_out_item classify_frame(mcdc_pkg::t_in_item f);
        mcdc_pkg::t_out_item r;
        logic [2:0] lvl;
        logic [2:0] single;
        logic [2:0] dbl;
        logic       pressed;
        logic [31:0] elapsed;
        int         dx;
        int         dy;
        longint     sum;
        r       = '0;
        single  = '0;
        dbl     = '0;
        lvl     = {f.middle_level, f.right_level, f.left_level};
        pressed = |(~btn_prev & lvl);
        // releases: double when inside the window (modulo 2^32), else single
        for (int i = 0; i < mcdc_pkg::NUM_BTN; i++) begin
            if (btn_prev[i] && !lvl[i]) begin
                elapsed = f.time_ms - click_stamp[i];
                if (elapsed < {16'd0, dbl_window}) begin
                    dbl[i]         = 1'b1;
                    click_stamp[i] = '0;
                end else begin
                    single[i]      = 1'b1;
                    click_stamp[i] = f.time_ms;
                end
                drag_flag[i] = 1'b0;
            end
        end
        // a press re-anchors; otherwise a move past the threshold drags
        if (pressed) begin
            anchor_x = f.pos_x;
            anchor_y = f.pos_y;
        end else begin
            dx = f.pos_x - anchor_x;
            dy = f.pos_y - anchor_y;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > int'(drag_thresh) || dy > int'(drag_thresh))
                drag_flag = drag_flag | lvl;
        end
        btn_prev = lvl;
        // saturating wheel sum
        r.wheel_before = wheel_sum;
        sum = longint'(wheel_sum) + longint'(f.wheel_step);
        if (sum > WHEEL_MAX) sum = WHEEL_MAX;
        if (sum < WHEEL_MIN) sum = WHEEL_MIN;
        wheel_sum     = sum[31:0];
        r.wheel_total = wheel_sum;
        r.left_single   = single[0];
        r.left_double   = dbl[0];
        r.right_single  = single[1];
        r.right_double  = dbl[1];
        r.middle_single = single[2];
        r.middle_double = dbl[2];
        r.left_drag     = drag_flag[0];
        r.right_drag    = drag_flag[1];
        r.middle_drag   = drag_flag[2];
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dbl_window  = mcdc_pkg::DBL_WINDOW_RST;
            drag_thresh = mcdc_pkg::DRAG_THRESH_RST;
            btn_prev    = '0;
            drag_flag   = '0;
            anchor_x    = '0;
            anchor_y    = '0;
            wheel_sum   = '0;
            for (int i = 0; i < mcdc_pkg::NUM_BTN; i++)
                click_stamp[i] = '0;
            predicted_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (mcdc_pkg::t_cfg_reg'(i_cfg_addr))
                    mcdc_pkg::CFG_DBL_WINDOW:  dbl_window  = i_cfg_wdata;
                    mcdc_pkg::CFG_DRAG_THRESH: drag_thresh = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // result side first: the oldest prediction belongs to it
            if (i_out_tvalid && i_out_tready) begin
                got_frame = mcdc_pkg::t_out_item'(i_out_tdata);
                if (predicted_frames.size() == 0) begin
                    $error("result transaction with no frame outstanding");
                    mismatch_count++;
                end else begin
                    want_frame = predicted_frames.pop_front();
                    check_field("left_single", want_frame.left_single,
                                got_frame.left_single);
                    check_field("left_double", want_frame.left_double,
                                got_frame.left_double);
                    check_field("right_single", want_frame.right_single,
                                got_frame.right_single);
                    check_field("right_double", want_frame.right_double,
                                got_frame.right_double);
                    check_field("middle_single", want_frame.middle_single,
                                got_frame.middle_single);
                    check_field("middle_double", want_frame.middle_double,
                                got_frame.middle_double);
                    check_field("left_drag", want_frame.left_drag, got_frame.left_drag);
                    check_field("right_drag", want_frame.right_drag, got_frame.right_drag);
                    check_field("middle_drag", want_frame.middle_drag,
                                got_frame.middle_drag);
                    check_field("wheel_total", want_frame.wheel_total,
                                got_frame.wheel_total);
                    check_field("wheel_before", want_frame.wheel_before,
                                got_frame.wheel_before);
                end
            end
            if (i_in_tvalid && i_in_tready)
                predicted_frames.push_back(
                    classify_frame(mcdc_pkg::t_in_item'(i_in_tdata)));
        end
        o_pending    <= predicted_frames.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> sim/tb_mouse_click_drag_classifier.sv
`timescale 1ns / 100ps

module tb_mouse_click_drag_classifier;

    localparam int RUN_LIMIT = 600000;
    localparam int PHASE_FRAMES = 200;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [0:0]                 i_cfg_addr = '0;
    logic [15:0]                i_cfg_wdata = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [mcdc_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [mcdc_pkg::OUT_W-1:0] m_axis_tdata;

    int          mismatches;
    int          pending;
    int          cycle_count = 0;
    int unsigned stall_left = 0;
    int unsigned stall_len;
    bit          no_idle = 1'b0;

    // Random walk state for well-formed pointer traffic
    logic [15:0] walk_x = '0;
    logic [15:0] walk_y = '0;
    logic [2:0]  held = '0;
    logic [31:0] now_ms = '0;
    int unsigned win_now = 32'(mcdc_pkg::DBL_WINDOW_RST);
    int unsigned step_span = 4;

    always #4 i_clk = ~i_clk;

    mouse_click_drag_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    click_drag_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            stall_len = pick_gap();
            if (stall_len == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_len - 1;
            end
        end
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("mouse_click_drag_classifier: mismatch");
            $finish;
        end
    end

    // One input transaction, with an optional idle gap ahead of it
    task automatic send_frame(input logic [15:0] x, input logic [15:0] y,
                              input logic [2:0] lv, input logic [31:0] t,
                              input logic [7:0] w);
        mcdc_pkg::t_in_item f;
        int unsigned        gap;
        f              = '0;
        f.pos_x        = x;
        f.pos_y        = y;
        f.left_level   = lv[0];
        f.right_level  = lv[1];
        f.middle_level = lv[2];
        f.time_ms      = t;
        f.wheel_step   = w;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Mostly plausible pointer motion and button activity, some pure noise
    task automatic send_random_frame();
        int unsigned r;
        logic [7:0]  w;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            send_frame(16'($urandom), 16'($urandom), 3'($urandom), $urandom,
                       8'($urandom));
        end else begin
            for (int i = 0; i < mcdc_pkg::NUM_BTN; i++)
                if ($urandom_range(0, 3) == 0)
                    held[i] = ~held[i];
            if ($urandom_range(0, 99) < 5) begin
                walk_x = 16'($urandom);
                walk_y = 16'($urandom);
            end else begin
                walk_x = walk_x + 16'($urandom_range(0, 2 * step_span)) - 16'(step_span);
                walk_y = walk_y + 16'($urandom_range(0, 2 * step_span)) - 16'(step_span);
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                now_ms = now_ms + $urandom_range(0, win_now);
            else if (r < 85)
                now_ms = now_ms + $urandom_range(win_now, 3 * win_now + 10);
            else if (r < 97)
                now_ms = now_ms + $urandom_range(0, 70000);
            else
                now_ms = $urandom;
            if ($urandom_range(0, 99) < 75)
                w = 8'($urandom_range(0, 6)) - 8'd3;
            else
                w = 8'($urandom);
            send_frame(walk_x, walk_y, held, now_ms, w);
        end
    endtask

    // Let every outstanding result drain before touching the registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input mcdc_pkg::t_cfg_reg idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] window, input logic [7:0] thresh,
                             input bit quiet);
        wait_idle();
        write_reg(mcdc_pkg::CFG_DBL_WINDOW, window);
        // upper write bits are don't-care for the threshold
        write_reg(mcdc_pkg::CFG_DRAG_THRESH, {8'($urandom), thresh});
        win_now   = 32'(window);
        step_span = thresh / 4 + 4;
        no_idle   = quiet;
        repeat (PHASE_FRAMES) send_random_frame();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at reset settings (window 500 ms, threshold 3)
        send_frame(16'd0, 16'd0, 3'b001, 32'd10, 8'd0);
        send_frame(16'd2, -16'sd3, 3'b001, 32'd20, 8'd1);         // at threshold: no drag
        send_frame(16'd0, 16'd0, 3'b000, 32'd30, -8'sd1);         // release right after reset
        send_frame(16'h8000, 16'h7FFF, 3'b010, 32'd1000, 8'h7F);
        send_frame(16'h7FFF, 16'h8000, 3'b010, 32'd1010, 8'h80);  // full-scale distance
        send_frame(16'h7FFF, 16'h8000, 3'b000, 32'd1100, 8'd0);   // single
        send_frame(16'h7FFF, 16'h8000, 3'b010, 32'd1200, 8'd0);
        send_frame(16'h7FFF, 16'h8000, 3'b000, 32'd1300, 8'd0);   // double
        send_frame(16'd100, 16'd100, 3'b100, 32'hFFFF_FF00, 8'd0);
        send_frame(16'd100, 16'd100, 3'b000, 32'hFFFF_FF10, 8'd0);
        send_frame(16'd100, 16'd100, 3'b100, 32'hFFFF_FFF0, 8'd0);
        send_frame(16'd100, 16'd100, 3'b000, 32'h0000_0050, 8'd0); // stamp wraps
        send_frame(16'd200, 16'd200, 3'b111, 32'h100, 8'd0);
        send_frame(16'd203, 16'd197, 3'b111, 32'h110, 8'd0);
        send_frame(16'd204, 16'd200, 3'b111, 32'h120, 8'd0);      // all three drag
        send_frame(16'd200, 16'd204, 3'b110, 32'h130, 8'd5);
        send_frame(16'd200, 16'd200, 3'b000, 32'h1000, 8'd0);
        send_frame(16'hFFFF, 16'hFFFF, 3'b000, 32'hFFFF_FFFF, 8'h80);
        send_frame(16'd0, 16'd0, 3'b001, 32'd5000, 8'h7F);
        send_frame(16'd0, 16'd0, 3'b000, 32'd5000, 8'd0);
        send_frame(16'd0, 16'd0, 3'b001, 32'd5100, 8'd0);
        send_frame(16'd0, 16'd0, 3'b000, 32'd5500, 8'd0);         // exactly the window
        send_frame(16'd0, 16'd0, 3'b001, 32'd5600, 8'd0);
        send_frame(16'd0, 16'd0, 3'b000, 32'd5999, 8'd0);         // one under the window
        now_ms = 32'd6000;

        // Random phases over a spread of settings
        run_phase(mcdc_pkg::DBL_WINDOW_RST, mcdc_pkg::DRAG_THRESH_RST, 1'b0);
        run_phase(16'd0, 8'd0, 1'b0);
        run_phase(16'hFFFF, 8'hFF, 1'b1);
        run_phase(16'd1, 8'd1, 1'b0);
        run_phase(16'($urandom_range(1, 2000)), 8'($urandom_range(0, 40)), 1'b0);
        run_phase(16'($urandom), 8'($urandom), 1'b0);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("mouse_click_drag_classifier: match");
        else
            $display("mouse_click_drag_classifier: mismatch");
        $finish;
    end

endmodule

>>> mouse_click_drag_classifier.f
sv/mcdc_pkg.sv
sv/mouse_click_drag_classifier.sv
sim/click_drag_checker.sv
sim/tb_mouse_click_drag_classifier.sv
